@@ sv/lbr_pkg.sv @@
// Package for the letterbox bilinear resize block.
// Holds sizes, fixed-point constants, register indexes and the structs
// shared by the map, blend and top-level modules. No dependencies.
package lbr_pkg;

  // Frame store and canvas limits.
  localparam int MAX_SOURCE_WIDTH  = 1024;
  localparam int MAX_SOURCE_HEIGHT = 1024;
  localparam int MAX_CANVAS        = 1024;

  localparam int COL_W      = $clog2(MAX_SOURCE_WIDTH);
  localparam int ROW_W      = $clog2(MAX_SOURCE_HEIGHT);
  localparam int BANK_AW    = COL_W + ROW_W - 2;
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int NUM_BANKS  = 4;

  // Field and datapath widths.
  localparam int POS_W  = 10;
  localparam int LVL_W  = 8;
  localparam int PIX_W  = 3 * LVL_W;
  localparam int CH_W   = 16;
  localparam int DIM_W  = 11;
  localparam int STEP_W = 24;
  localparam int PROD_W = POS_W + STEP_W;
  localparam int IDX_W  = PROD_W - 16;
  localparam int FRAC_W = 17;
  localparam int WGT_W  = 33;
  localparam int SUM_W  = 40;
  localparam int QU_W   = 24;
  localparam int CFG_W  = 24;
  localparam int CIDX_W = 3;

  // Fixed-point constants.
  localparam logic [FRAC_W-1:0] ONE_Q16   = 17'h10000;
  localparam logic [CH_W-1:0]   GRAY_KEEP = 16'd29184;
  localparam logic [CH_W-1:0]   GRAY_NORM = 16'd14649;
  localparam logic [QU_W-1:0]   RECIP_255 = 24'h808081;
  localparam logic [SUM_W:0]    HALF_LVL  = 41'h000_0080_0000;
  localparam logic [SUM_W:0]    HALF_NORM = 41'(255 * 65536);

  // Configuration register indexes.
  typedef enum logic [CIDX_W-1:0] {
    REG_SOURCE_WIDTH   = 3'd0,
    REG_SOURCE_HEIGHT  = 3'd1,
    REG_CANVAS_SIZE    = 3'd2,
    REG_RESIZED_WIDTH  = 3'd3,
    REG_RESIZED_HEIGHT = 3'd4,
    REG_SOURCE_STEP    = 3'd5,
    REG_KEEP_LEVELS    = 3'd6
  } cfg_reg_t;

  typedef logic [BANK_AW-1:0] baddr_t;

  typedef struct packed {
    logic [DIM_W-1:0]  src_w;
    logic [DIM_W-1:0]  src_h;
    logic [DIM_W-1:0]  canvas;
    logic [DIM_W-1:0]  rsz_w;
    logic [DIM_W-1:0]  rsz_h;
    logic [STEP_W-1:0] step;
    logic              keep;
  } cfg_t;

  typedef struct packed {
    logic              cmd;
    logic [POS_W-1:0]  load_x;
    logic [POS_W-1:0]  load_y;
    logic [LVL_W-1:0]  red;
    logic [LVL_W-1:0]  green;
    logic [LVL_W-1:0]  blue;
    logic [POS_W-1:0]  canvas_x;
    logic [POS_W-1:0]  canvas_y;
  } in_item_t;

  typedef struct packed {
    logic              en;
    logic [1:0]        bank;
    baddr_t            addr;
    logic [PIX_W-1:0]  data;
  } wr_t;

  // Request leaving the address stage towards the blend pipeline.
  typedef struct packed {
    logic              live;
    logic              in_rect;
    logic [POS_W-1:0]  cx;
    logic [POS_W-1:0]  cy;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fy;
    logic              ix0;
    logic              iy0;
  } item_t;

endpackage

@@ sv/lbr_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// Used for the four banks of the frame store. No dependencies.
module lbr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             re,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/lbr_map.sv @@
// Front of the pipeline: input register, letterbox test, source mapping and
// frame store address generation. Depends on lbr_pkg.
module lbr_map import lbr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     adv,
  input  logic     in_take,
  input  in_item_t in_item,
  output logic     slot_free,
  output wr_t      wr,
  output baddr_t   rd_addr [NUM_BANKS],
  output item_t    item
);

  // Stage 1: input register.
  logic     v1_r;
  in_item_t it1_r;

  // Stage 2: letterbox test done.
  logic             v2_r, req2_r, inside2_r;
  logic [POS_W-1:0] cx2_r, cy2_r, xpos2_r, ypos2_r, lx2_r, ly2_r;
  logic [PIX_W-1:0] pix2_r;

  // Stage 3: source position products.
  logic              v3_r, req3_r, inside3_r;
  logic [POS_W-1:0]  cx3_r, cy3_r, lx3_r, ly3_r;
  logic [PIX_W-1:0]  pix3_r;
  logic [PROD_W-1:0] sx3_r, sy3_r;

  // Combinational values.
  logic [DIM_W-1:0]  canvas, pad_x, pad_y, cx_e, cy_e, xoff, yoff;
  logic              inside_nxt;
  logic [DIM_W-1:0]  sw, sh;
  logic [IDX_W-1:0]  ixf, iyf;
  logic              clamp_x, clamp_y;
  logic [COL_W-1:0]  ix, colsum [NUM_BANKS];
  logic [ROW_W-1:0]  iy, rowsum [NUM_BANKS];
  logic [DIM_W-1:0]  sw_m2, sh_m2;
  logic [FRAC_W-1:0] fx, fy;
  logic              load_ok;

  assign slot_free = ~v1_r;

  // Stage 1 register: refills whenever it moves on or is empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv || !v1_r) begin
      v1_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      it1_r <= in_item;
    end
  end

  // Letterbox rectangle and offset inside it.
  always_comb begin
    canvas = (cfg.canvas > DIM_W'(MAX_CANVAS)) ? DIM_W'(MAX_CANVAS) : cfg.canvas;
    pad_x  = (cfg.rsz_w < canvas) ? ((canvas - cfg.rsz_w) >> 1) : '0;
    pad_y  = (cfg.rsz_h < canvas) ? ((canvas - cfg.rsz_h) >> 1) : '0;
    cx_e   = DIM_W'(it1_r.canvas_x);
    cy_e   = DIM_W'(it1_r.canvas_y);
    xoff   = cx_e - pad_x;
    yoff   = cy_e - pad_y;
    inside_nxt = (cx_e < canvas) && (cy_e < canvas) &&
                 (cx_e >= pad_x) && (xoff < cfg.rsz_w) &&
                 (cy_e >= pad_y) && (yoff < cfg.rsz_h);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Stage 2 and stage 3 payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      req2_r    <= it1_r.cmd;
      inside2_r <= inside_nxt;
      cx2_r     <= it1_r.canvas_x;
      cy2_r     <= it1_r.canvas_y;
      xpos2_r   <= xoff[POS_W-1:0];
      ypos2_r   <= yoff[POS_W-1:0];
      lx2_r     <= it1_r.load_x;
      ly2_r     <= it1_r.load_y;
      pix2_r    <= {it1_r.red, it1_r.green, it1_r.blue};

      req3_r    <= req2_r;
      inside3_r <= inside2_r;
      cx3_r     <= cx2_r;
      cy3_r     <= cy2_r;
      lx3_r     <= lx2_r;
      ly3_r     <= ly2_r;
      pix3_r    <= pix2_r;
      sx3_r     <= PROD_W'(xpos2_r) * PROD_W'(cfg.step);
      sy3_r     <= PROD_W'(ypos2_r) * PROD_W'(cfg.step);
    end
  end

  // Base index and fraction, clamped at the last row and column.
  always_comb begin
    sw = (cfg.src_w < DIM_W'(2)) ? DIM_W'(2) :
         (cfg.src_w > DIM_W'(MAX_SOURCE_WIDTH)) ? DIM_W'(MAX_SOURCE_WIDTH) : cfg.src_w;
    sh = (cfg.src_h < DIM_W'(2)) ? DIM_W'(2) :
         (cfg.src_h > DIM_W'(MAX_SOURCE_HEIGHT)) ? DIM_W'(MAX_SOURCE_HEIGHT) : cfg.src_h;
    sw_m2   = sw - DIM_W'(2);
    sh_m2   = sh - DIM_W'(2);
    ixf     = sx3_r[PROD_W-1:16];
    iyf     = sy3_r[PROD_W-1:16];
    clamp_x = ixf >= IDX_W'(sw - DIM_W'(1));
    clamp_y = iyf >= IDX_W'(sh - DIM_W'(1));
    ix      = clamp_x ? sw_m2[COL_W-1:0] : ixf[COL_W-1:0];
    iy      = clamp_y ? sh_m2[ROW_W-1:0] : iyf[ROW_W-1:0];
    fx      = clamp_x ? ONE_Q16 : {1'b0, sx3_r[15:0]};
    fy      = clamp_y ? ONE_Q16 : {1'b0, sy3_r[15:0]};
  end

  // Each bank holds one parity of column and row, so the four neighbours
  // always fall into four different banks.
  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      colsum[b]  = ix + COL_W'(ix[0] ^ b[0]);
      rowsum[b]  = iy + ROW_W'(iy[0] ^ b[1]);
      rd_addr[b] = {rowsum[b][ROW_W-1:1], colsum[b][COL_W-1:1]};
    end
  end

  // Loads write at the read stage, so store order follows beat order.
  always_comb begin
    load_ok   = (DIM_W'(lx3_r) < DIM_W'(MAX_SOURCE_WIDTH)) &&
                (DIM_W'(ly3_r) < DIM_W'(MAX_SOURCE_HEIGHT));
    wr.en     = adv && v3_r && !req3_r && load_ok;
    wr.bank   = {ly3_r[0], lx3_r[0]};
    wr.addr   = {ly3_r[ROW_W-1:1], lx3_r[COL_W-1:1]};
    wr.data   = pix3_r;
  end

  always_comb begin
    item.live    = v3_r && req3_r;
    item.in_rect = inside3_r;
    item.cx      = cx3_r;
    item.cy      = cy3_r;
    item.fx      = fx;
    item.fy      = fy;
    item.ix0     = ix[0];
    item.iy0     = iy[0];
  end

endmodule

@@ sv/lbr_blend.sv @@
// Back of the pipeline: bilinear weights, channel sums, output formatting
// and the output register. Depends on lbr_pkg.
module lbr_blend import lbr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             keep,
  input  item_t            item,
  input  logic [PIX_W-1:0] rd_data [NUM_BANKS],
  output logic             out_valid,
  output logic [POS_W-1:0] out_x,
  output logic [POS_W-1:0] out_y,
  output logic [CH_W-1:0]  out_chan [3],
  output logic             out_pad
);

  // Stage 4: request whose store read is in flight.
  logic  live4_r;
  item_t it4_r;

  // Stage 5: weights and neighbour pixels.
  logic              live5_r, inside5_r;
  logic [POS_W-1:0]  cx5_r, cy5_r;
  logic [WGT_W-1:0]  w5_r [4];
  logic [PIX_W-1:0]  px5_r [4];

  // Stage 6: exact sums.
  logic              live6_r, inside6_r;
  logic [POS_W-1:0]  cx6_r, cy6_r;
  logic [SUM_W-1:0]  s6_r [3];

  // Stage 7: both output formats.
  logic              live7_r, inside7_r;
  logic [POS_W-1:0]  cx7_r, cy7_r;
  logic [CH_W-1:0]   lvl7_r [3];
  logic [CH_W-1:0]   q7_r [3];

  // Output register.
  logic              out_valid_r, out_pad_r;
  logic [POS_W-1:0]  out_x_r, out_y_r;
  logic [CH_W-1:0]   out_chan_r [3];

  logic [FRAC_W-1:0] fx1, fy1;
  logic [2*FRAC_W-1:0] wp [4];
  logic [PIX_W-1:0]  px [4];
  logic [SUM_W+2:0]  acc [3];
  logic [SUM_W:0]    lsum [3], nsum [3];
  logic [2*QU_W-1:0] qprod [3];
  logic [CH_W-1:0]   chan_nxt [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live4_r     <= 1'b0;
      live5_r     <= 1'b0;
      live6_r     <= 1'b0;
      live7_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      live4_r     <= item.live;
      live5_r     <= live4_r;
      live6_r     <= live5_r;
      live7_r     <= live6_r;
      out_valid_r <= live7_r;
    end
  end

  // Weights and neighbour selection by index parity.
  always_comb begin
    fx1   = ONE_Q16 - it4_r.fx;
    fy1   = ONE_Q16 - it4_r.fy;
    wp[0] = fx1 * fy1;
    wp[1] = it4_r.fx * fy1;
    wp[2] = fx1 * it4_r.fy;
    wp[3] = it4_r.fx * it4_r.fy;
    px[0] = rd_data[{it4_r.iy0, it4_r.ix0}];
    px[1] = rd_data[{it4_r.iy0, ~it4_r.ix0}];
    px[2] = rd_data[{~it4_r.iy0, it4_r.ix0}];
    px[3] = rd_data[{~it4_r.iy0, ~it4_r.ix0}];
  end

  // Channel sums: red in the top byte.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = '0;
      for (int k = 0; k < 4; k++) begin
        acc[c] = acc[c] + (SUM_W+3)'(px5_r[k][PIX_W-1-LVL_W*c -: LVL_W] * w5_r[k]);
      end
    end
  end

  // Rounding; the divide by 255 is a multiply by its reciprocal.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      lsum[c]  = {1'b0, s6_r[c]} + HALF_LVL;
      nsum[c]  = {1'b0, s6_r[c]} + HALF_NORM;
      qprod[c] = nsum[c][SUM_W:17] * RECIP_255;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (!inside7_r) begin
        chan_nxt[c] = keep ? GRAY_KEEP : GRAY_NORM;
      end else begin
        chan_nxt[c] = keep ? lvl7_r[c] : q7_r[c];
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      it4_r     <= item;

      inside5_r <= it4_r.in_rect;
      cx5_r     <= it4_r.cx;
      cy5_r     <= it4_r.cy;
      for (int k = 0; k < 4; k++) begin
        w5_r[k]  <= wp[k][WGT_W-1:0];
        px5_r[k] <= px[k];
      end

      inside6_r <= inside5_r;
      cx6_r     <= cx5_r;
      cy6_r     <= cy5_r;
      for (int c = 0; c < 3; c++) begin
        s6_r[c] <= acc[c][SUM_W-1:0];
      end

      inside7_r <= inside6_r;
      cx7_r     <= cx6_r;
      cy7_r     <= cy6_r;
      for (int c = 0; c < 3; c++) begin
        lvl7_r[c] <= lsum[c][SUM_W-1:24];
        q7_r[c]   <= qprod[c][46:31];
      end

      out_pad_r <= !inside7_r;
      out_x_r   <= cx7_r;
      out_y_r   <= cy7_r;
      for (int c = 0; c < 3; c++) begin
        out_chan_r[c] <= chan_nxt[c];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_pad   = out_pad_r;
  assign out_chan  = out_chan_r;

endmodule

@@ sv/letterbox_bilinear_resize_top.sv @@
// Top level of the letterbox bilinear resize block: configuration registers,
// the four-bank frame store and the map and blend pipelines.
// Depends on lbr_pkg, lbr_ram, lbr_map and lbr_blend.
//
//  Channel   Direction  Beat contents
//  in_*      input      tuser: cmd; tdata: load and request fields
//  out_*     output     tuser: is_padding; tdata: position and channels
//  cfg_*     input      register index and data, one write per cycle
//
// One beat is accepted per cycle unless stalled; a request result passes
// stages 1 to 7 and the output register. The rate comes from the four store
// banks split by column and row parity, each reading one neighbour per cycle.
// Reset clears the pipeline and sets the registers to defaults; the store has
// no clearing pass and holds undefined data until written.
// While a result waits, the pipeline holds and the input register takes one more beat if empty.
module letterbox_bilinear_resize_top import lbr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // load_x[9:0], load_y[19:10], red[27:20], green[35:28], blue[43:36],
  // canvas_x[53:44], canvas_y[63:54]
  input  logic [63:0]       in_tdata,
  // cmd[0]
  input  logic              in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // out_x[9:0], out_y[19:10], chan_red[35:20], chan_green[51:36],
  // chan_blue[67:52], zero [71:68]
  output logic [71:0]       out_tdata,
  // is_padding[0]
  output logic              out_tuser,
  input  logic              cfg_wr_en,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  cfg_t             cfg_r;
  in_item_t         in_item;
  logic             adv, in_take, slot_free;
  wr_t              wr;
  baddr_t           rd_addr [NUM_BANKS];
  logic [PIX_W-1:0] rd_data [NUM_BANKS];
  logic [NUM_BANKS-1:0] bank_we;
  item_t            item;
  logic [POS_W-1:0] o_x, o_y;
  logic [CH_W-1:0]  o_chan [3];
  logic             o_pad;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_w  <= DIM_W'(640);
      cfg_r.src_h  <= DIM_W'(480);
      cfg_r.canvas <= DIM_W'(640);
      cfg_r.rsz_w  <= DIM_W'(640);
      cfg_r.rsz_h  <= DIM_W'(480);
      cfg_r.step   <= STEP_W'(65536);
      cfg_r.keep   <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SOURCE_WIDTH:   cfg_r.src_w  <= cfg_data[DIM_W-1:0];
        REG_SOURCE_HEIGHT:  cfg_r.src_h  <= cfg_data[DIM_W-1:0];
        REG_CANVAS_SIZE:    cfg_r.canvas <= cfg_data[DIM_W-1:0];
        REG_RESIZED_WIDTH:  cfg_r.rsz_w  <= cfg_data[DIM_W-1:0];
        REG_RESIZED_HEIGHT: cfg_r.rsz_h  <= cfg_data[DIM_W-1:0];
        REG_SOURCE_STEP:    cfg_r.step   <= cfg_data[STEP_W-1:0];
        REG_KEEP_LEVELS:    cfg_r.keep   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Handshake: the pipeline moves unless a result waits untaken.
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv || slot_free;
  assign in_take   = in_tvalid && in_tready;

  always_comb begin
    in_item.cmd      = in_tuser;
    in_item.load_x   = in_tdata[9:0];
    in_item.load_y   = in_tdata[19:10];
    in_item.red      = in_tdata[27:20];
    in_item.green    = in_tdata[35:28];
    in_item.blue     = in_tdata[43:36];
    in_item.canvas_x = in_tdata[53:44];
    in_item.canvas_y = in_tdata[63:54];
  end

  lbr_map u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .adv       (adv),
    .in_take   (in_take),
    .in_item   (in_item),
    .slot_free (slot_free),
    .wr        (wr),
    .rd_addr   (rd_addr),
    .item      (item)
  );

  // Frame store banks.
  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    assign bank_we[b] = wr.en && (wr.bank == 2'(b));

    lbr_ram #(
      .WIDTH (PIX_W),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk     (clk),
      .we      (bank_we[b]),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .re      (adv),
      .rd_addr (rd_addr[b]),
      .rd_data (rd_data[b])
    );
  end

  lbr_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .keep      (cfg_r.keep),
    .item      (item),
    .rd_data   (rd_data),
    .out_valid (out_tvalid),
    .out_x     (o_x),
    .out_y     (o_y),
    .out_chan  (o_chan),
    .out_pad   (o_pad)
  );

  assign out_tdata = {4'b0, o_chan[2], o_chan[1], o_chan[0], o_y, o_x};
  assign out_tuser = o_pad;

  // Assertions.
  a_one_bank_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(bank_we))
    else $error("more than one frame store bank written in a cycle");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled without a waiting result");

  a_pad_is_gray: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |->
      (o_chan[0] == o_chan[1]) && (o_chan[1] == o_chan[2]))
    else $error("padding pixel with unequal channels");

endmodule

@@ tb/letterbox_bilinear_resize_top_test.sv @@
// Self-checking testbench for letterbox_bilinear_resize_top: a scoreboard class predicts
// every canvas pixel from its own copy of the frame store and the registers.
// Depends on lbr_pkg and the block's RTL.
module letterbox_bilinear_resize_top_test;
  import lbr_pkg::*;

  typedef struct {
    bit [9:0]  x;
    bit [9:0]  y;
    bit [15:0] red;
    bit [15:0] green;
    bit [15:0] blue;
    bit        pad;
  } canvas_pixel_t;

  // Scoreboard: keeps the predicted store and registers and the pixels still owed.
  class resize_scoreboard;
    bit [23:0]     frame [int];
    int unsigned   regs [7];
    canvas_pixel_t owed [$];
    int            errors;

    function new();
      regs = '{640, 480, 640, 640, 480, 65536, 0};
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, bit [23:0] val);
      if (idx == REG_SOURCE_STEP) regs[idx] = val;
      else if (idx == REG_KEEP_LEVELS) regs[idx] = val[0];
      else regs[idx] = val[10:0];
    endfunction

    function void map_axis(int unsigned pos, int unsigned size,
                           output int unsigned base, output int unsigned frac);
      longint unsigned s;
      s = longint'(pos) * regs[REG_SOURCE_STEP];
      if ((s >> 16) >= size - 1) begin
        base = size - 2;
        frac = 65536;
      end else begin
        base = s >> 16;
        frac = s & 16'hFFFF;
      end
    endfunction

    // Works out whether a canvas pixel is inside the rectangle and its source position.
    function bit locate(int unsigned cx, int unsigned cy, output int unsigned ix,
                        output int unsigned iy, output int unsigned fx,
                        output int unsigned fy);
      int unsigned canvas, sw, sh, pad_x, pad_y, rw, rh;
      canvas = regs[REG_CANVAS_SIZE] > MAX_CANVAS ? MAX_CANVAS : regs[REG_CANVAS_SIZE];
      sw = regs[REG_SOURCE_WIDTH];
      sw = sw < 2 ? 2 : (sw > MAX_SOURCE_WIDTH ? MAX_SOURCE_WIDTH : sw);
      sh = regs[REG_SOURCE_HEIGHT];
      sh = sh < 2 ? 2 : (sh > MAX_SOURCE_HEIGHT ? MAX_SOURCE_HEIGHT : sh);
      rw = regs[REG_RESIZED_WIDTH];
      rh = regs[REG_RESIZED_HEIGHT];
      pad_x = rw < canvas ? (canvas - rw) / 2 : 0;
      pad_y = rh < canvas ? (canvas - rh) / 2 : 0;
      ix = 0; iy = 0; fx = 0; fy = 0;
      if (!(cx < canvas && cy < canvas && cx >= pad_x && cx - pad_x < rw &&
            cy >= pad_y && cy - pad_y < rh))
        return 0;
      map_axis(cx - pad_x, sw, ix, fx);
      map_axis(cy - pad_y, sh, iy, fy);
      return 1;
    endfunction

    function bit [15:0] to_format(longint unsigned s);
      if (regs[REG_KEEP_LEVELS] != 0) return (s + (64'd1 << 23)) >> 24;
      return (s + 64'd255 * 65536) / (64'd255 * 131072);
    endfunction

    // Notes an accepted input beat: a load updates the store, a request owes a pixel.
    function void note_beat(bit cmd, bit [63:0] d);
      canvas_pixel_t p;
      int unsigned ix, iy, fx, fy;
      longint unsigned w [4];
      bit [23:0] nb [4];
      longint unsigned s;
      bit [15:0] ch [3];
      if (!cmd) begin
        frame[d[19:10] * 1024 + d[9:0]] = {d[27:20], d[35:28], d[43:36]};
        return;
      end
      p.x = d[53:44];
      p.y = d[63:54];
      if (!locate(p.x, p.y, ix, iy, fx, fy)) begin
        p.pad = 1;
        p.red = to_format(64'd114 << 32);
      end else begin
        p.pad = 0;
        w[0] = longint'(65536 - fx) * (65536 - fy);
        w[1] = longint'(fx) * (65536 - fy);
        w[2] = longint'(65536 - fx) * fy;
        w[3] = longint'(fx) * fy;
        nb[0] = frame[iy * 1024 + ix];
        nb[1] = frame[iy * 1024 + ix + 1];
        nb[2] = frame[(iy + 1) * 1024 + ix];
        nb[3] = frame[(iy + 1) * 1024 + ix + 1];
        for (int c = 0; c < 3; c++) begin
          s = 0;
          for (int k = 0; k < 4; k++) s += ((nb[k] >> (16 - 8 * c)) & 8'hFF) * w[k];
          ch[c] = to_format(s);
        end
        p.red = ch[0];
        p.green = ch[1];
        p.blue = ch[2];
      end
      if (p.pad) begin
        p.green = p.red;
        p.blue = p.red;
      end
      owed.push_back(p);
    endfunction

    // Compares an output beat with the oldest owed pixel.
    function void check_beat(bit [71:0] d, bit u);
      canvas_pixel_t e;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected output beat: tdata=%h tuser=%b", d, u);
        return;
      end
      e = owed.pop_front();
      if (d[9:0] != e.x || d[19:10] != e.y || d[35:20] != e.red ||
          d[51:36] != e.green || d[67:52] != e.blue || u != e.pad) begin
        errors++;
        if (errors <= 10)
          $display({"Mismatch: expected x=%0d y=%0d rgb=%0d/%0d/%0d pad=%b, ",
                    "got x=%0d y=%0d rgb=%0d/%0d/%0d pad=%b"},
                   e.x, e.y, e.red, e.green, e.blue, e.pad,
                   d[9:0], d[19:10], d[35:20], d[51:36], d[67:52], u);
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_tvalid, in_tready, in_tuser;
  logic [63:0] in_tdata;
  logic        out_tvalid, out_tready, out_tuser;
  logic [71:0] out_tdata;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;

  resize_scoreboard sb;
  bit  no_idle;
  int  beats_in;
  int  quiet_cycles;

  letterbox_bilinear_resize_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Sends one beat, with a random gap first unless no_idle is set, and notes it once accepted.
  task automatic send_beat(bit cmd, bit [63:0] d);
    if (!no_idle) begin
      while ($urandom_range(99) < 30) begin
        @(negedge clk);
        in_tvalid = 0;
      end
    end
    @(negedge clk);
    in_tvalid = 1;
    in_tuser = cmd;
    in_tdata = d;
    do @(posedge clk); while (!in_tready);
    sb.note_beat(cmd, d);
    beats_in++;
  endtask

  task automatic load_pixel(int unsigned x, int unsigned y, bit [23:0] rgb);
    bit [63:0] d;
    d = {$urandom, $urandom};
    d[9:0] = x;
    d[19:10] = y;
    d[43:20] = {rgb[7:0], rgb[15:8], rgb[23:16]};
    send_beat(0, d);
  endtask

  // Requests a canvas pixel, loading first any neighbour the store lacks.
  task automatic request_pixel(int unsigned cx, int unsigned cy);
    int unsigned ix, iy, fx, fy;
    bit [63:0] d;
    if (sb.locate(cx, cy, ix, iy, fx, fy)) begin
      for (int k = 0; k < 4; k++) begin
        if (!sb.frame.exists((iy + k / 2) * 1024 + ix + k % 2))
          load_pixel(ix + k % 2, iy + k / 2, $urandom);
      end
    end
    d = {$urandom, $urandom};
    d[53:44] = cx;
    d[63:54] = cy;
    send_beat(1, d);
  endtask

  // Waits for every owed pixel and for the pipeline to empty, then writes registers.
  task automatic write_settings(bit [23:0] vals [7]);
    @(negedge clk);
    in_tvalid = 0;
    while (sb.owed.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    for (int i = 0; i < 7; i++) begin
      cfg_wr_en = 1;
      cfg_index = i;
      cfg_data = vals[i];
      sb.set_reg(cfg_reg_t'(i), vals[i]);
      @(negedge clk);
    end
    cfg_wr_en = 0;
  endtask

  // Receiver: random stalls, one long hold-off once the input has run for a while.
  initial begin
    int hold;
    bit held;
    hold = 0;
    held = 0;
    out_tready = 0;
    forever begin
      @(negedge clk);
      if (!held && beats_in >= 600) begin
        held = 1;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        out_tready = 0;
      end else begin
        out_tready = no_idle || ($urandom_range(99) >= 30);
      end
    end
  end

  // Output checking and the stall watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_beat(out_tdata, out_tuser);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= 20000) begin
        $display("** letterbox_bilinear_resize_top: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    bit [23:0] vals [7];
    int unsigned canvas, sw, sh, rw, rh;
    sb = new();
    no_idle = 0;
    beats_in = 0;
    quiet_cycles = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tuser = 0;
    in_tdata = '0;
    cfg_wr_en = 0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (2) @(negedge clk);
    rst_n = 1;

    // Directed: field extremes, rectangle edges and pixels outside the canvas.
    vals = '{4, 4, 10, 8, 6, 24'h008000, 0};
    write_settings(vals);
    load_pixel(0, 0, 24'hFFFFFF);
    load_pixel(1023, 1023, 24'hFFFFFF);
    load_pixel(1023, 0, 24'h000000);
    load_pixel(0, 1023, 24'hFF00FF);
    request_pixel(1, 2);
    request_pixel(0, 0);
    request_pixel(8, 7);
    request_pixel(9, 5);
    request_pixel(4, 1);
    request_pixel(1023, 1023);
    request_pixel(5, 8);
    vals = '{4, 4, 10, 8, 6, 24'h008000, 1};
    write_settings(vals);
    request_pixel(1, 2);
    request_pixel(8, 7);
    request_pixel(0, 5);

    // Random phases, alternating fixed extreme settings with small random ones.
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: vals = '{640, 480, 640, 640, 480, 65536, 0};
        2: vals = '{0, 2047, 2047, 0, 1024, 24'hFFFFFF, 1};
        4: vals = '{1024, 1024, 1024, 1024, 1024, 24'hFFFFFF, 1};
        6: vals = '{2, 2, 0, 5, 5, 24'h010000, 0};
        8: vals = '{3, 1, 8, 20, 20, 0, 0};
        10: vals = '{1024, 1024, 2047, 512, 1000, 24'h020000, 1};
        default: begin
          sw = $urandom_range(2, 12);
          sh = $urandom_range(2, 12);
          canvas = $urandom_range(1, 40);
          rw = $urandom_range(1, canvas);
          rh = $urandom_range(1, canvas);
          vals = '{sw, sh, canvas, rw, rh,
                   ((sw > sh ? sw : sh) << 16) / (rw > rh ? rw : rh), $urandom_range(1)};
          if ($urandom_range(3) == 0) vals[5] = $urandom_range(24'hFFFFFF);
        end
      endcase
      write_settings(vals);
      no_idle = (ph == 5);
      canvas = sb.regs[REG_CANVAS_SIZE] > 1024 ? 1024 : sb.regs[REG_CANVAS_SIZE];
      for (int n = 0; n < 80; n++) begin
        if ($urandom_range(99) < 25) begin
          if ($urandom_range(1)) load_pixel($urandom_range(1023), $urandom_range(1023), $urandom);
          else load_pixel($urandom_range(11), $urandom_range(11), $urandom);
        end else if ($urandom_range(3) == 0 || canvas == 0) begin
          request_pixel($urandom_range(1023), $urandom_range(1023));
        end else begin
          request_pixel($urandom_range(canvas - 1), $urandom_range(canvas - 1));
        end
      end
    end

    // Drain and report.
    @(negedge clk);
    in_tvalid = 0;
    no_idle = 0;
    while (sb.owed.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (sb.errors == 0) begin
      $display("** letterbox_bilinear_resize_top: PASSED **");
    end else begin
      $display("** letterbox_bilinear_resize_top: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/lbr_pkg.sv
sv/lbr_ram.sv
sv/lbr_map.sv
sv/lbr_blend.sv
sv/letterbox_bilinear_resize_top.sv
tb/letterbox_bilinear_resize_top_test.sv
